// ----- sv/sfke_pkg.sv -----
package sfke_pkg;

  // k-mer length in amino acids (1..8)
  localparam int KMER_LEN   = 8;
  localparam int NUM_FRAMES = 3;

  localparam int AA_W      = 5;
  localparam int TAG_W     = 3;
  localparam int AA_WIN_W  = AA_W * KMER_LEN;
  localparam int TAG_WIN_W = TAG_W * KMER_LEN;
  localparam int CNT_W     = $clog2(KMER_LEN + 1);
  localparam int NUM_PAIRS = (KMER_LEN + 1) / 2;

  localparam int AA_SHIFT  = 25;
  localparam int KMER_W    = 61;
  localparam int VAL_W     = KMER_W - AA_SHIFT;
  localparam int SEQ_ID_W  = 32;
  localparam int POS_W     = 16;
  localparam int FRAME_W   = 3;

  localparam logic [VAL_W-1:0] AA_RADIX = VAL_W'(21);

  // nucleotide codes
  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_T = 2'd2;
  localparam logic [1:0] BASE_G = 2'd3;

  typedef struct packed {
    logic [1:0]          base;
    logic                strand;
    logic                sequence_start;
    logic [SEQ_ID_W-1:0] seq_id;
  } sfke_in_t;

  typedef struct packed {
    logic [KMER_W-1:0]   kmer_code;
    logic [SEQ_ID_W-1:0] seq_id_out;
    logic [POS_W-1:0]    position;
    logic [FRAME_W-1:0]  frame;
  } sfke_out_t;

  // codon -> amino acid, index {b0, b1, b2}
  localparam logic [AA_W-1:0] CODON_AA [64] = '{
    5'd11, 5'd2,  5'd2,  5'd11, 5'd16, 5'd16, 5'd16, 5'd16,
    5'd9,  5'd9,  5'd9,  5'd12, 5'd1,  5'd15, 5'd15, 5'd1,
    5'd5,  5'd8,  5'd8,  5'd5,  5'd14, 5'd14, 5'd14, 5'd14,
    5'd10, 5'd10, 5'd10, 5'd10, 5'd1,  5'd1,  5'd1,  5'd1,
    5'd20, 5'd18, 5'd18, 5'd20, 5'd15, 5'd15, 5'd15, 5'd15,
    5'd10, 5'd13, 5'd13, 5'd10, 5'd20, 5'd4,  5'd4,  5'd17,
    5'd6,  5'd3,  5'd3,  5'd6,  5'd0,  5'd0,  5'd0,  5'd0,
    5'd19, 5'd19, 5'd19, 5'd19, 5'd7,  5'd7,  5'd7,  5'd7
  };

  // synonymous-codon tag: third base, except AGG/TTG -> 4, AGA/TTA/TGA -> 5
  function automatic logic [TAG_W-1:0] codon_tag(input logic [1:0] b0,
                                                 input logic [1:0] b1,
                                                 input logic [1:0] b2);
    logic [TAG_W-1:0] t;
    t = {1'b0, b2};
    if (b0 == BASE_A && b1 == BASE_G && b2 == BASE_G) t = 3'd4;
    if (b0 == BASE_A && b1 == BASE_G && b2 == BASE_A) t = 3'd5;
    if (b0 == BASE_T && b1 == BASE_T && b2 == BASE_G) t = 3'd4;
    if (b0 == BASE_T && b1 == BASE_T && b2 == BASE_A) t = 3'd5;
    if (b0 == BASE_T && b1 == BASE_G && b2 == BASE_A) t = 3'd5;
    return t;
  endfunction

  // 21^idx, elaboration-time constant at every call site
  function automatic logic [VAL_W-1:0] pow21(input int idx);
    logic [VAL_W-1:0] p;
    p = VAL_W'(1);
    for (int k = 0; k < idx; k++) p = p * AA_RADIX;
    return p;
  endfunction

  function automatic logic [VAL_W-1:0] aa_weight(input logic [AA_W-1:0] aa,
                                                 input int idx);
    return VAL_W'(aa) * pow21(idx);
  endfunction

endpackage

// ----- sv/six_frame_kmer_encoder.sv -----
// Six-frame amino-acid k-mer encoder. One nucleotide per transaction enters on
// in_data (base, strand, sequence_start, seq_id); from the third base of a
// strand on, each base completes a codon of the frame that is next in turn.
// The codon is translated to an amino acid and a synonymous-codon tag, and once
// that frame holds KMER_LEN amino acids a k-mer result transaction is produced:
// (base-21 value << 25) | tags, with the seq_id of the completing base, the
// k-mer start position in amino acids (saturating at 65535) and the frame
// (0-2 forward, 3-5 reverse). sequence_start clears all frame state before the
// base is taken. Rate: one base per cycle unless out_ready stalls the pipeline;
// a result passes the window, pair-sum and output registers before out_valid.
// The throughput is set by the per-base frame-state update; the weighted sum
// runs in two further pipeline stages (pair sums, then final sum) and each
// stage stalls only when the one after it is full and blocked. Results leave
// in the order of the bases that complete them.
module six_frame_kmer_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sfke_pkg::sfke_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sfke_pkg::sfke_out_t out_data
);

  typedef struct packed {
    logic [sfke_pkg::AA_WIN_W-1:0]  aa_win;
    logic [sfke_pkg::TAG_WIN_W-1:0] tags;
    logic [sfke_pkg::SEQ_ID_W-1:0]  seq_id;
    logic [sfke_pkg::POS_W-1:0]     pos;
    logic [sfke_pkg::FRAME_W-1:0]   frame;
  } win_stage_t;

  typedef struct packed {
    logic [sfke_pkg::NUM_PAIRS-1:0][sfke_pkg::VAL_W-1:0] psum;
    logic [sfke_pkg::TAG_WIN_W-1:0] tags;
    logic [sfke_pkg::SEQ_ID_W-1:0]  seq_id;
    logic [sfke_pkg::POS_W-1:0]     pos;
    logic [sfke_pkg::FRAME_W-1:0]   frame;
  } sum_stage_t;

  // ---------------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------------
  logic [1:0] phase_r, phase_nxt;    // frame of the next completed codon
  logic [3:0] prev_r, prev_nxt;      // last two bases, older in [3:2]
  logic [1:0] seen_r, seen_nxt;      // bases seen on this strand, saturating at 2

  logic [sfke_pkg::AA_WIN_W-1:0]  aa_win_r  [sfke_pkg::NUM_FRAMES];
  logic [sfke_pkg::AA_WIN_W-1:0]  aa_win_nxt[sfke_pkg::NUM_FRAMES];
  logic [sfke_pkg::TAG_WIN_W-1:0] tag_win_r  [sfke_pkg::NUM_FRAMES];
  logic [sfke_pkg::TAG_WIN_W-1:0] tag_win_nxt[sfke_pkg::NUM_FRAMES];
  logic [sfke_pkg::CNT_W-1:0]     cnt_r  [sfke_pkg::NUM_FRAMES];
  logic [sfke_pkg::CNT_W-1:0]     cnt_nxt[sfke_pkg::NUM_FRAMES];
  logic [sfke_pkg::POS_W-1:0]     pos_r  [sfke_pkg::NUM_FRAMES];
  logic [sfke_pkg::POS_W-1:0]     pos_nxt[sfke_pkg::NUM_FRAMES];

  // pipeline stages
  logic       win_valid_r, sum_valid_r, out_valid_r;
  win_stage_t win_r, win_nxt;
  sum_stage_t sum_r, sum_nxt;
  sfke_pkg::sfke_out_t out_r, out_nxt;
  logic       win_load;             // accepted base completes a k-mer

  logic accept;
  logic out_adv, sum_adv, win_adv;

  // each stage moves when it is empty or its successor moves
  assign out_adv  = !out_valid_r || out_ready;
  assign sum_adv  = !sum_valid_r || out_adv;
  assign win_adv  = !win_valid_r || sum_adv;
  assign in_ready = win_adv;
  assign accept   = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Per-base update: codon lookup and window shift of the active frame
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [1:0]                     eff_phase;
    logic [3:0]                     eff_prev;
    logic [1:0]                     eff_seen;
    logic [1:0]                     fsel;
    logic [1:0]                     b0, b1;
    logic [sfke_pkg::AA_W-1:0]      aa;
    logic [sfke_pkg::TAG_W-1:0]     tag;
    logic [sfke_pkg::AA_WIN_W-1:0]  cur_aa;
    logic [sfke_pkg::TAG_WIN_W-1:0] cur_tag;
    logic [sfke_pkg::CNT_W-1:0]     cur_cnt;
    logic [sfke_pkg::POS_W-1:0]     cur_pos;
    logic [sfke_pkg::CNT_W-1:0]     new_cnt;

    // a sequence start clears everything before this base is taken
    eff_phase = in_data.sequence_start ? 2'd0 : phase_r;
    eff_prev  = in_data.sequence_start ? 4'd0 : prev_r;
    eff_seen  = in_data.sequence_start ? 2'd0 : seen_r;
    for (int f = 0; f < sfke_pkg::NUM_FRAMES; f++) begin
      aa_win_nxt[f]  = in_data.sequence_start ? '0 : aa_win_r[f];
      tag_win_nxt[f] = in_data.sequence_start ? '0 : tag_win_r[f];
      cnt_nxt[f]     = in_data.sequence_start ? '0 : cnt_r[f];
      pos_nxt[f]     = in_data.sequence_start ? '0 : pos_r[f];
    end

    fsel = (eff_phase > 2'd2) ? 2'd0 : eff_phase;
    b0   = eff_prev[3:2];
    b1   = eff_prev[1:0];
    aa   = sfke_pkg::CODON_AA[{b0, b1, in_data.base}];
    tag  = sfke_pkg::codon_tag(b0, b1, in_data.base);

    cur_aa  = '0;
    cur_tag = '0;
    cur_cnt = '0;
    cur_pos = '0;
    for (int f = 0; f < sfke_pkg::NUM_FRAMES; f++) begin
      if (fsel == 2'(f)) begin
        cur_aa  = aa_win_nxt[f];
        cur_tag = tag_win_nxt[f];
        cur_cnt = cnt_nxt[f];
        cur_pos = pos_nxt[f];
      end
    end

    new_cnt = (cur_cnt < sfke_pkg::CNT_W'(sfke_pkg::KMER_LEN)) ?
              cur_cnt + 1'b1 : cur_cnt;

    win_nxt.aa_win = {aa, cur_aa[sfke_pkg::AA_WIN_W-1:sfke_pkg::AA_W]};
    win_nxt.tags   = {tag, cur_tag[sfke_pkg::TAG_WIN_W-1:sfke_pkg::TAG_W]};
    win_nxt.seq_id = in_data.seq_id;
    win_nxt.pos    = cur_pos;
    win_nxt.frame  = in_data.strand ? 3'(fsel) + 3'd3 : 3'(fsel);

    win_load = 1'b0;
    if (eff_seen < 2'd2) begin
      // still gathering the first two bases of the strand
      seen_nxt  = eff_seen + 2'd1;
      prev_nxt  = {eff_prev[1:0], in_data.base};
      phase_nxt = eff_phase;
    end else begin
      seen_nxt  = eff_seen;
      prev_nxt  = {eff_prev[1:0], in_data.base};
      phase_nxt = (fsel >= 2'd2) ? 2'd0 : fsel + 2'd1;
      win_load  = (new_cnt >= sfke_pkg::CNT_W'(sfke_pkg::KMER_LEN));
      for (int f = 0; f < sfke_pkg::NUM_FRAMES; f++) begin
        if (fsel == 2'(f)) begin
          aa_win_nxt[f]  = win_nxt.aa_win;
          tag_win_nxt[f] = win_nxt.tags;
          cnt_nxt[f]     = new_cnt;
          if (win_load && cur_pos != '1) pos_nxt[f] = cur_pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      prev_r  <= '0;
      seen_r  <= '0;
      for (int f = 0; f < sfke_pkg::NUM_FRAMES; f++) begin
        aa_win_r[f]  <= '0;
        tag_win_r[f] <= '0;
        cnt_r[f]     <= '0;
        pos_r[f]     <= '0;
      end
    end else if (accept) begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      seen_r  <= seen_nxt;
      for (int f = 0; f < sfke_pkg::NUM_FRAMES; f++) begin
        aa_win_r[f]  <= aa_win_nxt[f];
        tag_win_r[f] <= tag_win_nxt[f];
        cnt_r[f]     <= cnt_nxt[f];
        pos_r[f]     <= pos_nxt[f];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Weighted sum: pairs of 21^i terms, then the final sum and code assembly
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [sfke_pkg::VAL_W-1:0] hi_term;
    for (int p = 0; p < sfke_pkg::NUM_PAIRS; p++) begin
      if (2 * p + 1 < sfke_pkg::KMER_LEN) begin
        hi_term = sfke_pkg::aa_weight(
          win_r.aa_win[sfke_pkg::AA_W*(2*p+1) +: sfke_pkg::AA_W], 2 * p + 1);
      end else begin
        hi_term = '0;
      end
      sum_nxt.psum[p] = sfke_pkg::aa_weight(
        win_r.aa_win[sfke_pkg::AA_W*(2*p) +: sfke_pkg::AA_W], 2 * p) + hi_term;
    end
    sum_nxt.tags   = win_r.tags;
    sum_nxt.seq_id = win_r.seq_id;
    sum_nxt.pos    = win_r.pos;
    sum_nxt.frame  = win_r.frame;
  end

  always_comb begin
    logic [sfke_pkg::VAL_W-1:0] value;
    value = '0;
    for (int p = 0; p < sfke_pkg::NUM_PAIRS; p++) value = value + sum_r.psum[p];
    out_nxt.kmer_code  = {value,
                          {(sfke_pkg::AA_SHIFT - sfke_pkg::TAG_WIN_W){1'b0}},
                          sum_r.tags};
    out_nxt.seq_id_out = sum_r.seq_id;
    out_nxt.position   = sum_r.pos;
    out_nxt.frame      = sum_r.frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_valid_r <= 1'b0;
      sum_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (win_adv) win_valid_r <= accept && win_load;
      if (sum_adv) sum_valid_r <= win_valid_r;
      if (out_adv) out_valid_r <= sum_valid_r;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    if (win_adv && accept && win_load) win_r <= win_nxt;
    if (sum_adv && win_valid_r)        sum_r <= sum_nxt;
    if (out_adv && sum_valid_r)        out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- sv/sfke_checker.sv -----
module sfke_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sfke_pkg::sfke_out_t out_data
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // frame is 0..5 and the gap between tags and amino value stays zero
  a_out_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.frame <= 3'd5 &&
      out_data.kmer_code[sfke_pkg::AA_SHIFT-1:sfke_pkg::TAG_WIN_W] == '0)
    else $error("malformed result fields");

  // with no result waiting the pipeline can always take a base
  a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with no result pending");

endmodule

bind six_frame_kmer_encoder sfke_checker u_sfke_checker (.*);
